@@ sv/cdt_pkg.sv @@
// Shared types and constants for the countdown timer with adjust.
// Used by countdown_timer_with_adjust_top; depends on nothing else.
`default_nettype none

package cdt_pkg;

  // Event codes carried on the input channel's tuser
  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_START    = 3'd1,
    MODE_TOGGLE   = 3'd2,
    MODE_ADJ_UP   = 3'd3,
    MODE_ADJ_DOWN = 3'd4,
    MODE_RELOAD   = 3'd5
  } mode_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJUST   = 1'd1;

  localparam logic [31:0] MAX32          = 32'hFFFF_FFFF;
  localparam logic [21:0] MS_PER_S       = 22'd1000;
  localparam logic [32:0] ROUND_UP_MS    = 33'd999;
  localparam logic [21:0] ADJ_DELTA_RST  = 22'd60000;   // 60 s in ms
  localparam logic [22:0] SEC_PER_HOUR   = 23'd3600;
  localparam logic [11:0] SEC_PER_MIN    = 12'd60;

  // Reciprocals for exact division by constants
  // floor(x / 125)  for x < 2^30: (x * RECIP_125)  >> 37
  localparam logic [30:0] RECIP_125 = 31'd1099511628;
  // floor(x / 225)  for x < 2^19: (x * RECIP_225)  >> 27
  localparam logic [19:0] RECIP_225 = 20'd596524;
  // floor(x / 60)   for x < 2^12: (x * RECIP_60)   >> 18
  localparam logic [12:0] RECIP_60  = 13'd4370;

  // Timer status travelling down the result pipeline
  typedef struct packed {
    logic [31:0] remaining;
    logic [31:0] total;
    logic        running;
    logic        finished;
    logic        pulse;
  } stat_t;

endpackage

`default_nettype wire

@@ sv/countdown_timer_with_adjust_top.sv @@
// Countdown timer with adjust: event handling, timer state and time split.
// Depends on cdt_pkg for event codes, constants and the status struct.
//
// Usage:
//   Input channel (in_*): one event per transaction. in_tuser carries the
//   event code (tick, start, toggle pause, adjust up, adjust down, reload),
//   in_tdata the milliseconds elapsed since the last tick.
//   Result channel (out_*): one transaction per event with the state after
//   that event: remaining and total ms, running/finished flags, the
//   completion pulse and the remaining time rounded up to whole seconds as
//   hours, minutes and seconds.
//   Config channel (cfg_*): index 0 is the reload length in ms, index 1 the
//   adjust step in seconds. Always ready; write only while the block is idle.
// Timing: the timer state updates in the cycle an event is taken, then six
//   register stages carry the result, the time split needing three constant
//   reciprocal multiplies each followed by a register. One event is taken
//   every cycle while the result channel is not stalled.
// Reset clears the timer, the pipeline and loads the config defaults
//   (length 0, adjust 60 s). When the receiver stalls, the whole pipeline
//   holds and in_tready falls with it.
`default_nettype none

module countdown_timer_with_adjust_top #(
  parameter int unsigned FLOOR_MS = 10000
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // event input
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [15:0]                   in_tdata,   // [9:0] elapsed_ms
  input  wire logic [2:0]                    in_tuser,   // [2:0] mode
  // result output
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [31:0] remaining_out, [63:32] total_out, [64] is_running,
  // [65] is_finished, [66] completed_pulse, [77:67] hours,
  // [83:78] minutes, [89:84] seconds, [95:90] zero
  output logic [95:0]                        out_tdata,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  import cdt_pkg::*;

  localparam logic [31:0] FLOOR32 = 32'(FLOOR_MS);

  // configuration
  logic [31:0] duration_r;
  logic [21:0] adj_delta_r;   // adjust step already scaled to ms

  // timer state
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] tot_r, tot_nxt;
  logic        run_r, run_nxt;
  logic        fin_r, fin_nxt;
  logic        pulse_nxt;

  // pipeline
  logic        en;
  logic        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  stat_t       st1_r, st2_r, st3_r, st4_r, st5_r, st6_r;
  logic [22:0] secs2_r, secs3_r;
  logic [10:0] hrs3_r, hrs4_r, hrs5_r, hrs6_r;
  logic [11:0] rsec4_r, rsec5_r;
  logic [5:0]  min5_r, min6_r;
  logic [5:0]  sec6_r;

  logic        in_acc;
  mode_t       mode;
  logic [9:0]  elapsed;
  logic        usable;

  // adjust arithmetic
  logic [32:0] sum_up, tsum_up, lim_dn, tdif_dn;
  logic [31:0] new_up, chg_up, tcl_up, tot_up;
  logic [31:0] new_dn, chg_dn, tcl_dn, tot_dn;

  // time split arithmetic
  logic [32:0] rnd2;
  logic [60:0] prod2;
  logic [38:0] prod3;
  logic [22:0] hsec4;
  logic [24:0] prod5;
  logic [11:0] msec6;

  assign en        = !v6_r || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign mode      = mode_t'(in_tuser);
  assign elapsed   = in_tdata[9:0];
  assign usable    = (tot_r != '0) && !fin_r;

  // adjust up: saturate, move total by the applied change
  always_comb begin
    sum_up  = {1'b0, rem_r} + 33'(adj_delta_r);
    new_up  = sum_up[32] ? MAX32 : sum_up[31:0];
    chg_up  = new_up - rem_r;
    tsum_up = {1'b0, tot_r} + {1'b0, chg_up};
    tcl_up  = tsum_up[32] ? MAX32 : tsum_up[31:0];
    tot_up  = (tcl_up > new_up) ? tcl_up : new_up;
  end

  // adjust down: stop at the floor, total never below remaining
  always_comb begin
    lim_dn  = {1'b0, FLOOR32} + 33'(adj_delta_r);
    new_dn  = ({1'b0, rem_r} < lim_dn) ? FLOOR32 : (rem_r - 32'(adj_delta_r));
    chg_dn  = rem_r - new_dn;
    tdif_dn = {1'b0, tot_r} - {1'b0, chg_dn};
    tcl_dn  = tdif_dn[32] ? '0 : tdif_dn[31:0];
    tot_dn  = (tcl_dn > new_dn) ? tcl_dn : new_dn;
  end

  always_comb begin
    rem_nxt   = rem_r;
    tot_nxt   = tot_r;
    run_nxt   = run_r;
    fin_nxt   = fin_r;
    pulse_nxt = 1'b0;
    case (mode)
      MODE_TICK: begin
        if (run_r) begin
          if (rem_r <= 32'(elapsed)) begin
            rem_nxt = '0;
            run_nxt = 1'b0;
            if (!fin_r) begin
              fin_nxt   = 1'b1;
              pulse_nxt = 1'b1;
            end
          end else begin
            rem_nxt = rem_r - 32'(elapsed);
          end
        end
      end
      MODE_START: begin
        if (usable) run_nxt = 1'b1;
      end
      MODE_TOGGLE: begin
        if (usable) run_nxt = !run_r;
      end
      MODE_ADJ_UP: begin
        if (usable) begin
          rem_nxt = new_up;
          tot_nxt = tot_up;
        end
      end
      MODE_ADJ_DOWN: begin
        if (usable && (rem_r > FLOOR32)) begin
          rem_nxt = new_dn;
          tot_nxt = tot_dn;
        end
      end
      MODE_RELOAD: begin
        rem_nxt = duration_r;
        tot_nxt = duration_r;
        run_nxt = 1'b0;
        fin_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // config and timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r  <= '0;
      adj_delta_r <= ADJ_DELTA_RST;
      rem_r       <= '0;
      tot_r       <= '0;
      run_r       <= 1'b0;
      fin_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DURATION: duration_r  <= cfg_data;
          CFG_ADJUST:   adj_delta_r <= 22'(cfg_data[11:0]) * MS_PER_S;
          default: ;
        endcase
      end
      if (in_acc) begin
        rem_r <= rem_nxt;
        tot_r <= tot_nxt;
        run_r <= run_nxt;
        fin_r <= fin_nxt;
      end
    end
  end

  // time split: ceil to seconds, then hours, then minutes and seconds
  always_comb begin
    rnd2  = {1'b0, st1_r.remaining} + ROUND_UP_MS;
    prod2 = 61'(rnd2[32:3]) * 61'(RECIP_125);
    prod3 = 39'(secs2_r[22:4]) * 39'(RECIP_225);
    hsec4 = secs3_r - 23'(hrs3_r) * SEC_PER_HOUR;
    prod5 = 25'(rsec4_r) * 25'(RECIP_60);
    msec6 = rsec5_r - 12'(min5_r) * SEC_PER_MIN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // payload: advance with the pipeline, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      st1_r.remaining <= rem_nxt;
      st1_r.total     <= tot_nxt;
      st1_r.running   <= run_nxt;
      st1_r.finished  <= fin_nxt;
      st1_r.pulse     <= pulse_nxt;
      st2_r   <= st1_r;
      secs2_r <= prod2[59:37];
      st3_r   <= st2_r;
      secs3_r <= secs2_r;
      hrs3_r  <= prod3[37:27];
      st4_r   <= st3_r;
      hrs4_r  <= hrs3_r;
      rsec4_r <= hsec4[11:0];
      st5_r   <= st4_r;
      hrs5_r  <= hrs4_r;
      rsec5_r <= rsec4_r;
      min5_r  <= prod5[23:18];
      st6_r   <= st5_r;
      hrs6_r  <= hrs5_r;
      min6_r  <= min5_r;
      sec6_r  <= msec6[5:0];
    end
  end

  assign out_tvalid = v6_r;
  assign out_tdata  = {6'd0, sec6_r, min6_r, hrs6_r, st6_r.pulse, st6_r.finished,
                       st6_r.running, st6_r.total, st6_r.remaining};

`ifndef SYNTHESIS
  a_run_not_fin: assert property (@(posedge clk) disable iff (!rst_n)
    !(run_r && fin_r))
    else $error("timer running and finished at once");

  a_rem_le_tot: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= tot_r)
    else $error("remaining time above total");

  a_pulse_state: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && st6_r.pulse) |-> (st6_r.finished && !st6_r.running
                               && (st6_r.remaining == '0) && (sec6_r == '0)))
    else $error("completion pulse with inconsistent state");

  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> ((min6_r < 6'd60) && (sec6_r < 6'd60)))
    else $error("minutes or seconds out of range");
`endif

endmodule

`default_nettype wire
